FILE: design/orfct_pkg.sv
`default_nettype none

package orfct_pkg;

    localparam int POSITION_WIDTH = 32;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // codon index = first*16 + second*4 + third, bases A0 C1 G2 T3
    localparam logic [8*64-1:0] AMINO_TABLE =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV-Y-YSSSS-CWCLFLF";

    typedef enum logic [1:0] {
        PH_HEADER    = 2'd0,
        PH_SEARCH    = 2'd1,
        PH_TRANSLATE = 2'd2,
        PH_DONE      = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_RESIDUE = 2'd1,
        KIND_STOP    = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_of_record;
    } seq_item_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                residue;
        logic [POSITION_WIDTH-1:0] position;
    } res_item_t;

    // bit 2 flags a non-ACGT character
    function automatic logic [2:0] code_base(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CH_A:    code = 3'd0;
            CH_C:    code = 3'd1;
            CH_G:    code = 3'd2;
            CH_T:    code = 3'd3;
            default: code = 3'd4;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] amino_lookup(input logic [5:0] idx);
        logic [8:0] sel;
        sel = {~idx, 3'b000};
        return AMINO_TABLE[sel +: 8];
    endfunction

endpackage

`default_nettype wire

FILE: design/orfct_in_stage.sv
`default_nettype none

module orfct_in_stage
    import orfct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      seq_valid,
    input  wire seq_item_t seq_item,
    output logic           seq_stall,
    input  wire logic      take,
    output logic           item_valid,
    output seq_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    seq_item_t item_reg;

    assign seq_stall  = valid_reg && !take;
    assign valid_next = seq_stall ? valid_reg : seq_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!seq_stall && seq_valid)
        begin
            item_reg <= seq_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: design/orfct_core.sv
`default_nettype none

module orfct_core
    import orfct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      skip_header,
    input  wire logic      step,
    input  wire seq_item_t item,
    output logic           result_valid,
    output res_item_t      result
);

    phase_t                    phase_reg;
    phase_t                    phase_next;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    logic [5:0]                held_reg;
    logic [5:0]                held_next;
    logic [POSITION_WIDTH-1:0] index_reg;
    logic [POSITION_WIDTH-1:0] index_next;

    phase_t                    eff_phase;
    logic [1:0]                eff_count;
    logic [5:0]                eff_held;
    logic [POSITION_WIDTH-1:0] eff_index;
    logic                      hdr_skip;
    phase_t                    work_phase;
    logic                      active;
    logic [2:0]                code;
    logic                      codon_bad;
    logic [7:0]                aa;
    logic                      start_hit;
    logic                      codon_done;

    // start of record clears the record state before the character is seen
    assign eff_phase = item.start_of_record ? PH_HEADER : phase_reg;
    assign eff_count = item.start_of_record ? 2'd0 : count_reg;
    assign eff_held  = item.start_of_record ? 6'd0 : held_reg;
    assign eff_index = item.start_of_record ? '0 : index_reg;

    assign hdr_skip   = (eff_phase == PH_HEADER) && skip_header;
    assign work_phase = (eff_phase == PH_HEADER) ? PH_SEARCH : eff_phase;
    assign active     = step && !hdr_skip && (work_phase != PH_DONE) && (item.ch != CH_LF);

    assign code       = code_base(item.ch);
    assign codon_bad  = eff_held[2] | eff_held[5] | code[2];
    assign aa         = amino_lookup({eff_held[1:0], eff_held[4:3], code[1:0]});
    assign start_hit  = active && (work_phase == PH_SEARCH) && (eff_count == 2'd2)
                        && (item.ch == CH_G);
    assign codon_done = active && (work_phase == PH_TRANSLATE) && (eff_count == 2'd2);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        held_next  = held_reg;
        index_next = index_reg;
        if (step)
        begin
            phase_next = eff_phase;
            count_next = eff_count;
            held_next  = eff_held;
            index_next = eff_index;
            if (hdr_skip)
            begin
                if (item.ch == CH_LF)
                begin
                    phase_next = PH_SEARCH;
                end
            end
            else
            begin
                phase_next = work_phase;
            end
            if (active)
            begin
                index_next = eff_index + 1'b1;
                case (work_phase)
                    PH_SEARCH:
                    begin
                        if (start_hit)
                        begin
                            phase_next = PH_TRANSLATE;
                            count_next = 2'd0;
                            held_next  = 6'd0;
                        end
                        else if (eff_count == 2'd1 && item.ch == CH_T)
                        begin
                            count_next = 2'd2;
                        end
                        else if (item.ch == CH_A)
                        begin
                            count_next = 2'd1;
                        end
                        else
                        begin
                            count_next = 2'd0;
                        end
                    end
                    PH_TRANSLATE:
                    begin
                        case (eff_count)
                            2'd0:
                            begin
                                held_next  = {3'd0, code};
                                count_next = 2'd1;
                            end
                            2'd1:
                            begin
                                held_next  = {code, eff_held[2:0]};
                                count_next = 2'd2;
                            end
                            default:
                            begin
                                held_next  = 6'd0;
                                count_next = 2'd0;
                                if (!codon_bad && aa == CH_DASH)
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        phase_next = work_phase;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result_valid    = 1'b0;
        result.kind     = KIND_RESIDUE;
        result.residue  = CH_QUERY;
        result.position = eff_index - POSITION_WIDTH'(2);
        if (start_hit)
        begin
            result_valid   = 1'b1;
            result.kind    = KIND_START;
            result.residue = CH_M;
        end
        else if (codon_done)
        begin
            result_valid = 1'b1;
            if (codon_bad)
            begin
                result.kind    = KIND_RESIDUE;
                result.residue = CH_QUERY;
            end
            else if (aa == CH_DASH)
            begin
                result.kind    = KIND_STOP;
                result.residue = CH_DASH;
            end
            else
            begin
                result.kind    = KIND_RESIDUE;
                result.residue = aa;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= 2'd0;
            held_reg  <= 6'd0;
            index_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            index_reg <= index_next;
        end
    end

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> step)
        else $error("result without a request");

    a_start_enters_translate: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_START) |=> (phase_reg == PH_TRANSLATE))
        else $error("start codon did not open translation");

    a_stop_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == KIND_STOP) |=> (phase_reg == PH_DONE))
        else $error("stop codon did not end record");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("base count out of range");

endmodule

`default_nettype wire

FILE: design/orfct_out_stage.sv
`default_nettype none

module orfct_out_stage
    import orfct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      result_valid,
    input  wire res_item_t result,
    output logic           take,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign take       = !(valid_reg && res_stall);
    assign valid_next = take ? result_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && result_valid)
        begin
            item_reg <= result;
        end
    end

    assign res_valid = valid_reg;
    assign res_item  = item_reg;

endmodule

`default_nettype wire

FILE: design/orf_codon_translator.sv
// Open reading frame translator: takes one FASTA character per request on
// seq, drops the header line when skip_header is set, ignores newlines, finds
// the first ATG and then emits one residue per codon on res, ending the
// record at the first stop codon. A new character can be taken every cycle
// while res is not stalled; a result passes through the input register, then
// the result register. Position wraps at 32 bits. skip_header resets to 1.
`default_nettype none

module orf_codon_translator
    import orfct_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    input  wire logic      seq_valid,
    output logic           seq_stall,
    input  wire seq_item_t seq_item,
    output logic           res_valid,
    input  wire logic      res_stall,
    output res_item_t      res_item
);

    logic      skip_header_reg;
    logic      skip_header_next;
    logic      take;
    logic      item_valid;
    seq_item_t item;
    logic      result_valid;
    res_item_t result;

    assign skip_header_next = cfg_we ? cfg_wdata : skip_header_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_header_reg <= 1'b1;
        end
        else
        begin
            skip_header_reg <= skip_header_next;
        end
    end

    orfct_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .seq_valid  (seq_valid),
        .seq_item   (seq_item),
        .seq_stall  (seq_stall),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    orfct_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .skip_header  (skip_header_reg),
        .step         (item_valid && take),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    orfct_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .result_valid (result_valid),
        .result       (result),
        .take         (take),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res_item     (res_item)
    );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
    import orfct_pkg::*;

    typedef enum logic [1:0] {
        ROW_PRED,
        ROW_FIXED,
        ROW_CFG
    } row_op_t;

    typedef struct {
        row_op_t    op;
        logic [7:0] ch;
        logic       sor;
        res_item_t  want;
    } plan_row_t;

    // codon index = first*16 + second*4 + third, bases A0 C1 G2 T3
    localparam logic [8*64-1:0] CODON_TABLE =
        "KNKNTTTTRSRSIIMIQHQHPPPPRRRRLLLLEDEDAAAAGGGGVVVV-Y-YSSSS-CWCLFLF";
    localparam int RANDOM_CHARS = 450;
    localparam int PHASES       = 6;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 4;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_wdata;
    logic      seq_valid;
    logic      seq_stall;
    seq_item_t seq_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    orf_codon_translator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .seq_valid (seq_valid),
        .seq_stall (seq_stall),
        .seq_item  (seq_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // translator state as seen by the testbench
    logic        skip_hdr   = 1'b1;
    phase_t      orf_phase  = PH_HEADER;
    logic [1:0]  orf_count  = 2'd0;
    logic [5:0]  orf_held   = 6'd0;
    logic [31:0] orf_index  = 32'd0;

    res_item_t   pending_residues[$];
    plan_row_t   directed_plan[$];

    int  errors     = 0;
    int  chars_sent = 0;
    int  n_starts   = 0;
    int  n_residues = 0;
    int  n_stops    = 0;
    bit  no_gaps    = 1'b0;
    bit  hold_req   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", pending_residues.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic translate_char(input seq_item_t it, output bit got, output res_item_t r);
        logic [31:0] here;
        logic [2:0]  code;
        logic [2:0]  b0;
        logic [2:0]  b1;
        logic [7:0]  aa;
        got = 1'b0;
        r = '0;
        if (it.start_of_record)
        begin
            orf_phase = PH_HEADER;
            orf_count = 2'd0;
            orf_held  = 6'd0;
            orf_index = 32'd0;
        end
        if (orf_phase == PH_HEADER)
        begin
            if (skip_hdr)
            begin
                if (it.ch == "\n")
                    orf_phase = PH_SEARCH;
                return;
            end
            orf_phase = PH_SEARCH;
        end
        if (orf_phase == PH_DONE || it.ch == "\n")
            return;
        here = orf_index;
        orf_index = orf_index + 32'd1;
        r.position = here - 32'd2;
        if (orf_phase == PH_SEARCH)
        begin
            if (orf_count == 2'd2 && it.ch == "G")
            begin
                orf_phase = PH_TRANSLATE;
                orf_count = 2'd0;
                orf_held  = 6'd0;
                r.kind    = KIND_START;
                r.residue = "M";
                got = 1'b1;
                return;
            end
            if (orf_count == 2'd1 && it.ch == "T")
                orf_count = 2'd2;
            else if (it.ch == "A")
                orf_count = 2'd1;
            else
                orf_count = 2'd0;
            return;
        end
        case (it.ch)
            "A":     code = 3'd0;
            "C":     code = 3'd1;
            "G":     code = 3'd2;
            "T":     code = 3'd3;
            default: code = 3'b100;
        endcase
        if (orf_count == 2'd0)
        begin
            orf_held  = {3'b000, code};
            orf_count = 2'd1;
            return;
        end
        if (orf_count == 2'd1)
        begin
            orf_held[5:3] = code;
            orf_count = 2'd2;
            return;
        end
        b0 = orf_held[2:0];
        b1 = orf_held[5:3];
        orf_count = 2'd0;
        orf_held  = 6'd0;
        got = 1'b1;
        if (b0[2] | b1[2] | code[2])
        begin
            r.kind    = KIND_RESIDUE;
            r.residue = "?";
            return;
        end
        aa = CODON_TABLE[8*(63 - {b0[1:0], b1[1:0], code[1:0]}) +: 8];
        if (aa == "-")
        begin
            orf_phase = PH_DONE;
            r.kind    = KIND_STOP;
            r.residue = "-";
        end
        else
        begin
            r.kind    = KIND_RESIDUE;
            r.residue = aa;
        end
    endtask

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic logic [7:0] pick_base();
        int r;
        r = $urandom_range(0, 19);
        if (r >= 17)
            return 8'($urandom_range(0, 255));
        case (r % 4)
            0:       return "A";
            1:       return "C";
            2:       return "G";
            default: return "T";
        endcase
    endfunction

    // present one request, wait for it to be taken, then log what it should give
    task automatic offer_char(input logic [7:0] ch, input logic sor,
                              input bit fixed = 1'b0, input res_item_t want = '0);
        int        gap;
        seq_item_t it;
        bit        got;
        res_item_t r;
        gap = draw_gap();
        it.ch = ch;
        it.start_of_record = sor;
        if (gap > 0)
        begin
            seq_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seq_valid <= 1'b1;
        seq_item  <= it;
        do
            @(posedge clk);
        while (seq_stall);
        chars_sent++;
        translate_char(it, got, r);
        if (fixed)
            pending_residues.push_back(want);
        else if (got)
            pending_residues.push_back(r);
    endtask

    task automatic write_skip(input logic v);
        seq_valid <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        skip_hdr = v;
    endtask

    task automatic plan(input row_op_t op, input logic [7:0] ch, input logic sor,
                        input kind_t k = KIND_START, input logic [7:0] aa = 8'h00,
                        input int unsigned pos = 0);
        plan_row_t row;
        row.op = op;
        row.ch = ch;
        row.sor = sor;
        row.want.kind = k;
        row.want.residue = aa;
        row.want.position = pos;
        directed_plan.push_back(row);
    endtask

    task automatic send_record(input int min_codons);
        int         n;
        logic [7:0] s2;
        logic [7:0] s3;
        if (min_codons == 0 && $urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(5, 20);
            offer_char(8'($urandom_range(0, 255)), 1'b1);
            repeat (n) offer_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            return;
        end
        offer_char(skip_hdr ? 8'h3E : pick_base(), 1'b1);
        if (skip_hdr)
        begin
            repeat ($urandom_range(0, 4)) offer_char(8'($urandom_range(0, 255)), 1'b0);
            offer_char("\n", 1'b0);
        end
        repeat ($urandom_range(0, 6)) offer_char($urandom_range(0, 1) ? 8'h41 : pick_base(), 1'b0);
        if (min_codons != 0 || $urandom_range(0, 9) != 0)
        begin
            offer_char("A", 1'b0);
            offer_char("T", 1'b0);
            offer_char("G", 1'b0);
        end
        repeat (min_codons + $urandom_range(0, 12))
        begin
            repeat (3) offer_char(pick_base(), 1'b0);
            if ($urandom_range(0, 7) == 0)
                offer_char("\n", 1'b0);
        end
        if ($urandom_range(0, 9) < 7)
        begin
            s2 = $urandom_range(0, 1) ? 8'h41 : 8'h47;
            s3 = (s2 == "G" || $urandom_range(0, 1) == 1) ? 8'h41 : 8'h47;
            offer_char("T", 1'b0);
            offer_char(s2, 1'b0);
            offer_char(s3, 1'b0);
        end
        repeat ($urandom_range(0, 3)) offer_char(pick_base(), 1'b0);
    endtask

    task automatic check_result(input res_item_t got);
        res_item_t want;
        if (pending_residues.size() == 0)
        begin
            if (errors < 10)
                $display("unexpected result: kind %0d residue %h position %0d",
                         got.kind, got.residue, got.position);
            errors++;
            return;
        end
        want = pending_residues.pop_front();
        case (want.kind)
            KIND_START:   n_starts++;
            KIND_RESIDUE: n_residues++;
            default:      n_stops++;
        endcase
        if (got.kind !== want.kind || got.residue !== want.residue
            || got.position !== want.position)
        begin
            if (errors < 10)
                $display({"mismatch: expected kind %0d residue %h position %0d, ",
                          "got kind %0d residue %h position %0d"},
                         want.kind, want.residue, want.position,
                         got.kind, got.residue, got.position);
            errors++;
        end
    endtask

    // result side: random hold-offs per request, plus one long hold on demand
    initial
    begin : result_side
        int wait_left;
        int long_left;
        res_stall = 1'b0;
        wait_left = 0;
        long_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
            begin
                check_result(res_item);
                wait_left = draw_gap();
            end
            if (hold_req)
            begin
                hold_req = 1'b0;
                long_left = LONG_HOLD;
            end
            if (long_left > 0)
            begin
                long_left--;
                res_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        int target;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        seq_valid = 1'b0;
        seq_item  = '0;

        // header skipped, overlapping start, Q codon, invalid letters, stop, done
        plan(ROW_PRED,  ">",   1'b1);
        plan(ROW_PRED,  8'hFF, 1'b0);
        plan(ROW_PRED,  "\n",  1'b0);
        plan(ROW_PRED,  "A",   1'b0);
        plan(ROW_PRED,  "A",   1'b0);
        plan(ROW_PRED,  "T",   1'b0);
        plan(ROW_FIXED, "G",   1'b0, KIND_START, "M", 1);
        plan(ROW_PRED,  "C",   1'b0);
        plan(ROW_PRED,  "A",   1'b0);
        plan(ROW_FIXED, "A",   1'b0, KIND_RESIDUE, "Q", 4);
        plan(ROW_PRED,  "\n",  1'b0);
        plan(ROW_PRED,  "a",   1'b0);
        plan(ROW_PRED,  8'h00, 1'b0);
        plan(ROW_FIXED, "\r",  1'b0, KIND_RESIDUE, "?", 7);
        plan(ROW_PRED,  "T",   1'b0);
        plan(ROW_PRED,  "G",   1'b0);
        plan(ROW_FIXED, "A",   1'b0, KIND_STOP, "-", 10);
        plan(ROW_PRED,  "A",   1'b0);
        // no header: the first character already counts
        plan(ROW_CFG,   8'h00, 1'b0);
        plan(ROW_PRED,  "A",   1'b1);
        plan(ROW_PRED,  "T",   1'b0);
        plan(ROW_FIXED, "G",   1'b0, KIND_START, "M", 0);
        plan(ROW_PRED,  "T",   1'b0);
        plan(ROW_PRED,  "G",   1'b0);
        plan(ROW_PRED,  "G",   1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].op == ROW_CFG)
                write_skip(directed_plan[i].ch[0]);
            else
                offer_char(directed_plan[i].ch, directed_plan[i].sor,
                           directed_plan[i].op == ROW_FIXED, directed_plan[i].want);
        end

        target = chars_sent;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_skip(ph % 2 == 0);
            target += RANDOM_CHARS / PHASES;
            if (ph == 2)
            begin
                no_gaps = 1'b1;
                hold_req = 1'b1;
                send_record(25);
            end
            while (chars_sent < target)
            begin
                no_gaps = ($urandom_range(0, 3) == 0);
                send_record(0);
            end
        end
        no_gaps = 1'b0;
        seq_valid <= 1'b0;

        while (pending_residues.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d characters sent over %0d header settings", chars_sent, PHASES + 2);
        $display("checked %0d starts, %0d residues, %0d stops", n_starts, n_residues, n_stops);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
